// File: design/sfp_pkg.sv
// sensor frame parser package: frame constants and the result record
// shared by the frame collector and the top level; no dependencies

package sfp_pkg;

  localparam int unsigned ByteW      = 8;
  localparam int unsigned WordW      = 16;
  localparam int unsigned PosW       = 4;
  localparam int unsigned DataBytes  = 10;
  localparam int unsigned DataW      = DataBytes * ByteW;

  localparam logic [ByteW-1:0] HeaderReset = 8'h2C;

  localparam logic [PosW-1:0] PosIdle     = 4'd0;
  localparam logic [PosW-1:0] PosChecksum = 4'd11;

  typedef struct packed {
    logic                    checksum_ok;
    logic [WordW-1:0]        voc_level;
    logic [WordW-1:0]        formaldehyde_level;
    logic [WordW-1:0]        eco2_level;
    logic signed [WordW-1:0] temperature_tenths;
    logic [WordW-1:0]        humidity_tenths;
    logic                    ever_valid;
  } result_t;

endpackage

// File: design/sensor_frame_parser_top.sv
// sensor frame parser top level: header register, frame collector and
// a two-entry result stage; uses sfp_pkg and sfp_frame_collect
//
//   channel  | handshake              | payload
//   ---------+------------------------+------------------------------------
//   in       | in_valid_i/in_ready_o  | rx_byte_i
//   out      | out_valid_o/out_ready_i| checksum_ok_o .. ever_valid_o
//   cfg      | cfg_we_i               | cfg_wdata_i (header value)
//
// one byte per cycle while in_ready_o is high; a result is built
// combinationally on its checksum byte and registered after the collector
// a skid entry holds a second result while the output stalls; input
// stalls only when both entries are full
// reset returns to idle, header value 0x2c, sticky flag clear

module sensor_frame_parser_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [sfp_pkg::ByteW-1:0]         cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [sfp_pkg::ByteW-1:0]         rx_byte_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              checksum_ok_o,
  output logic [sfp_pkg::WordW-1:0]         voc_level_o,
  output logic [sfp_pkg::WordW-1:0]         formaldehyde_level_o,
  output logic [sfp_pkg::WordW-1:0]         eco2_level_o,
  output logic signed [sfp_pkg::WordW-1:0]  temperature_tenths_o,
  output logic [sfp_pkg::WordW-1:0]         humidity_tenths_o,
  output logic                              ever_valid_o
);

  logic [sfp_pkg::ByteW-1:0] header_q;
  logic                      in_accept;
  logic                      res_valid;
  sfp_pkg::result_t          res;
  logic                      out_valid_q, skid_valid_q;
  sfp_pkg::result_t          out_q, skid_q;
  logic                      pop;

  assign in_ready_o = !skid_valid_q;
  assign in_accept  = in_valid_i && in_ready_o;
  assign pop        = out_valid_q && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q <= sfp_pkg::HeaderReset;
    end else if (cfg_we_i) begin
      header_q <= cfg_wdata_i;
    end
  end

  sfp_frame_collect u_collect (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .header_value_i (header_q),
    .byte_valid_i   (in_accept),
    .rx_byte_i      (rx_byte_i),
    .res_valid_o    (res_valid),
    .res_o          (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (res_valid) begin
      if (!out_valid_q || pop) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (pop) begin
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      if (!out_valid_q || pop) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end else if (pop && skid_valid_q) begin
      out_q <= skid_q;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign checksum_ok_o        = out_q.checksum_ok;
  assign voc_level_o          = out_q.voc_level;
  assign formaldehyde_level_o = out_q.formaldehyde_level;
  assign eco2_level_o         = out_q.eco2_level;
  assign temperature_tenths_o = out_q.temperature_tenths;
  assign humidity_tenths_o    = out_q.humidity_tenths;
  assign ever_valid_o         = out_q.ever_valid;

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry full while output register empty");

  a_good_sets_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.checksum_ok) |-> out_q.ever_valid)
    else $error("good frame without sticky flag");

  a_bad_zeroes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.checksum_ok) |->
      (out_q.voc_level == '0 && out_q.eco2_level == '0 &&
       out_q.humidity_tenths == '0))
    else $error("bad frame carries reading data");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && skid_valid_q) |-> 1'b0)
    else $error("result produced while both entries full");

endmodule

// File: design/sfp_frame_collect.sv
// frame collector: tracks byte position, running sum and data bytes,
// and builds the result record when the checksum byte arrives; uses sfp_pkg

module sfp_frame_collect (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [sfp_pkg::ByteW-1:0]     header_value_i,
  input  logic                          byte_valid_i,
  input  logic [sfp_pkg::ByteW-1:0]     rx_byte_i,
  output logic                          res_valid_o,
  output sfp_pkg::result_t              res_o
);

  logic [sfp_pkg::PosW-1:0]  pos_q, pos_d;
  logic [sfp_pkg::ByteW-1:0] sum_q, sum_d;
  logic                      seen_q, seen_d;
  logic [sfp_pkg::DataW-1:0] data_q, data_d;
  logic                      is_header;
  logic                      ok;
  logic [sfp_pkg::ByteW-1:0] sum_chk;

  assign is_header = (rx_byte_i == header_value_i);
  assign sum_chk   = sum_q + rx_byte_i;
  assign ok        = (sum_chk == '0);

  always_comb begin
    pos_d       = pos_q;
    sum_d       = sum_q;
    seen_d      = seen_q;
    data_d      = data_q;
    res_valid_o = 1'b0;
    if (byte_valid_i) begin
      if (is_header) begin
        pos_d = sfp_pkg::PosIdle + 4'd1;
        sum_d = rx_byte_i;
      end else if (pos_q == sfp_pkg::PosIdle) begin
        pos_d = sfp_pkg::PosIdle;
      end else if (pos_q < sfp_pkg::PosChecksum) begin
        data_d = {data_q[sfp_pkg::DataW-sfp_pkg::ByteW-1:0], rx_byte_i};
        sum_d  = sum_chk;
        pos_d  = pos_q + 4'd1;
      end else begin
        pos_d       = sfp_pkg::PosIdle;
        res_valid_o = 1'b1;
        if (ok) begin
          seen_d = 1'b1;
        end
      end
    end
  end

  always_comb begin
    res_o             = '0;
    res_o.checksum_ok = ok;
    res_o.ever_valid  = seen_q | ok;
    if (ok) begin
      res_o.voc_level          = data_q[79:64];
      res_o.formaldehyde_level = data_q[63:48];
      res_o.eco2_level         = data_q[47:32];
      res_o.temperature_tenths = data_q[31:16];
      res_o.humidity_tenths    = data_q[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= sfp_pkg::PosIdle;
      sum_q  <= '0;
      seen_q <= 1'b0;
    end else begin
      pos_q  <= pos_d;
      sum_q  <= sum_d;
      seen_q <= seen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

endmodule
